[src/ims_pkg.sv]
// Package for the integer merge sorter: capacity, widths and the item type
// passed along the chain of insertion cells. No dependencies.
package ims_pkg;

	// Largest set the chain holds; one cell per value
	localparam int unsigned MAX_ITEMS = 16;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

	// One value moving between cells, with its valid mark
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] val;
	} ims_item_t;

endpackage

[src/integer_merge_sorter_core.sv]
// Integer sorter top level: load control, a row of ims_cell insertion cells
// and the unload port. Depends on ims_pkg and ims_cell.
// Load: one value per cycle, the set closes on tlast or on a value past capacity.
// Settle: after closing, waits until no value is in flight
// between cells; the input is not ready then.
// Unload: while m_tready is high, one sorted value per cycle from cell 0 while the chain shifts left.
// Reset clears the cell valid bits, the fill count and the control state.
module integer_merge_sorter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value_in
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast    // last_out
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_UNLOAD
	} state_t;

	state_t                     state_q;
	logic [ims_pkg::CNT_W-1:0]  count_q;
	logic                       in_xfer;
	logic                       full;
	logic                       out_xfer;
	logic                       shift;
	logic                       busy;
	ims_pkg::ims_item_t         entry;
	ims_pkg::ims_item_t         slots  [ims_pkg::MAX_ITEMS];
	ims_pkg::ims_item_t         passes [ims_pkg::MAX_ITEMS];
	logic [ims_pkg::MAX_ITEMS-1:0] pass_vld;

	assign s_tready = (state_q == ST_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign full     = (count_q == ims_pkg::CNT_W'(ims_pkg::MAX_ITEMS));
	assign m_tvalid = (state_q == ST_UNLOAD) && slots[0].vld;
	assign m_tdata  = slots[0].val;
	assign m_tlast  = !slots[1].vld;
	assign out_xfer = m_tvalid && m_tready;
	assign shift    = out_xfer;

	// Feed an accepted value into cell 0 unless the chain is full
	assign entry.vld = in_xfer && !full;
	assign entry.val = s_tdata;

	// Chain of insertion cells
	for (genvar i = 0; i < ims_pkg::MAX_ITEMS; i++) begin : g_cell
		ims_pkg::ims_item_t left_i;
		ims_pkg::ims_item_t right_i;

		if (i == 0) begin : g_head
			assign left_i = entry;
		end else begin : g_body
			assign left_i = passes[i-1];
		end

		if (i == ims_pkg::MAX_ITEMS - 1) begin : g_tail
			assign right_i = '0;
		end else begin : g_mid
			assign right_i = slots[i+1];
		end

		ims_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (shift),
			.left       (left_i),
			.right_slot (right_i),
			.slot       (slots[i]),
			.pass       (passes[i])
		);

		assign pass_vld[i] = passes[i].vld;
	end

	// Any value still moving between cells
	assign busy = |pass_vld;

	// Control: fill count and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (full) begin
							state_q <= ST_SETTLE;
							count_q <= '0;
						end else if (s_tlast) begin
							state_q <= ST_SETTLE;
							count_q <= '0;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_SETTLE: begin
					if (!busy) begin
						state_q <= ST_UNLOAD;
					end
				end
				ST_UNLOAD: begin
					if (out_xfer && m_tlast) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// Loading and unloading never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output valid");

	// Fill count stays within capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ims_pkg::CNT_W'(ims_pkg::MAX_ITEMS))
		else $error("fill count beyond capacity");

	// No value is in flight while the chain shifts out
	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNLOAD) |-> !busy)
		else $error("value in flight during unload");

	// Unload always has a value at cell 0
	a_unload_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNLOAD) |-> slots[0].vld)
		else $error("unload with empty head cell");

	// After the final value leaves, the chain is empty and loading resumes
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_tlast) |=> (s_tready && !slots[0].vld))
		else $error("chain not empty after final value");
`endif

endmodule

[src/ims_cell.sv]
// One insertion cell: keeps the smaller of its stored value and the arriving
// value, hands the larger to its right neighbor. Shifts left while unloading.
// Depends on ims_pkg.
module ims_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,      // unload: take the right neighbor's value
	input  ims_pkg::ims_item_t left,      // value arriving from the left
	input  ims_pkg::ims_item_t right_slot,// stored value of the right neighbor
	output ims_pkg::ims_item_t slot,      // stored value
	output ims_pkg::ims_item_t pass       // registered value for the right neighbor
);

	logic                      slot_vld_q;
	logic [ims_pkg::DATA_W-1:0] slot_val_q;
	logic                      pass_vld_q;
	logic [ims_pkg::DATA_W-1:0] pass_val_q;
	logic                      keep_new;

	// New value wins the slot when the slot is empty or the new value is smaller
	assign keep_new = !slot_vld_q || ($signed(left.val) < $signed(slot_val_q));

	// Valid bits: insert, pass on, or shift left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (shift) begin
			slot_vld_q <= right_slot.vld;
			pass_vld_q <= 1'b0;
		end else begin
			pass_vld_q <= left.vld && slot_vld_q;
			if (left.vld) begin
				slot_vld_q <= 1'b1;
			end
		end
	end

	// Payload: keep the minimum, hand on the maximum
	always_ff @(posedge clk) begin
		if (shift) begin
			slot_val_q <= right_slot.val;
		end else if (left.vld) begin
			if (keep_new) begin
				slot_val_q <= left.val;
				pass_val_q <= slot_val_q;
			end else begin
				pass_val_q <= left.val;
			end
		end
	end

	assign slot.vld = slot_vld_q;
	assign slot.val = slot_val_q;
	assign pass.vld = pass_vld_q;
	assign pass.val = pass_val_q;

endmodule

[tb/ims_checker.sv]
// Checker for integer_merge_sorter_core: watches the input and output streams,
// predicts the sorted output of every closed set and compares it word by word.
// Depends on ims_pkg for the capacity and data width.
module ims_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value_in
	input  logic        s_tlast,   // last_item
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] sorted_value
	input  logic        m_tlast,   // last_out
	output int          mismatch_count,
	output int          results_pending,
	output int          results_checked,
	output int          sets_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [ims_pkg::DATA_W-1:0] value;
		logic                              last;
	} sorted_word_t;

	// Words still owed by the sorter, oldest first
	sorted_word_t expected_words[$];
	// Values of the set that is still being loaded
	logic signed [ims_pkg::DATA_W-1:0] open_set[$];

	// Sort the open set ascending (signed) and queue it as expected output
	task automatic close_set();
		logic signed [ims_pkg::DATA_W-1:0] ordered [ims_pkg::MAX_ITEMS];
		logic signed [ims_pkg::DATA_W-1:0] v;
		sorted_word_t                      w;
		int                                n;
		int                                i;
		int                                j;
		n = open_set.size();
		for (i = 0; i < n; i++) begin
			v = open_set[i];
			j = i;
			while (j > 0 && ordered[j-1] > v) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = v;
		end
		for (i = 0; i < n; i++) begin
			w.value = ordered[i];
			w.last  = (i == n - 1);
			expected_words.push_back(w);
		end
		open_set.delete();
		sets_closed++;
	endtask

	// Update the set for one accepted input transaction
	task automatic load_value(input logic [ims_pkg::DATA_W-1:0] word, input logic last);
		if (open_set.size() >= ims_pkg::MAX_ITEMS) begin
			// full store: drop the word and flush what is held
			close_set();
		end else begin
			open_set.push_back(word);
			if (last) begin
				close_set();
			end
		end
	endtask

	// Compare one output transaction with the oldest expected word
	task automatic check_word();
		sorted_word_t w;
		if (expected_words.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: unexpected output value=%0d last=%0b",
					$realtime, $signed(m_tdata), m_tlast);
			end
		end else begin
			w = expected_words.pop_front();
			results_checked++;
			if (m_tdata !== w.value || m_tlast !== w.last) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: output mismatch: expected value=%0d last=%0b,",
						$realtime, w.value, w.last,
						" got value=%0d last=%0b", $signed(m_tdata), m_tlast);
				end
			end
		end
	endtask

	initial begin
		mismatch_count  = 0;
		results_checked = 0;
		sets_closed     = 0;
	end

	// Check outputs before loading, a word never leaves in the cycle it enters
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			open_set.delete();
			results_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_word();
			end
			if (s_tvalid && s_tready) begin
				load_value(s_tdata, s_tlast);
			end
			results_pending <= expected_words.size();
		end
	end

endmodule

[tb/tb.sv]
// Top of the sorter testbench: clock, reset, input stimulus and output stalls.
// Depends on ims_pkg, integer_merge_sorter_core and ims_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int DIRECTED_CNT = 24;
	localparam int RANDOM_CNT   = 136;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	int mismatch_count;
	int results_pending;
	int results_checked;
	int sets_closed;
	int items_sent;
	int cycle_count;
	int hold_requests;
	int holds_served;

	integer_merge_sorter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ims_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending),
		.results_checked (results_checked),
		.sets_closed     (sets_closed)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Abort a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)      pick_gap = 0;
		else if (r < 85) pick_gap = $urandom_range(1, 2);
		else if (r < 97) pick_gap = $urandom_range(3, 8);
		else             pick_gap = $urandom_range(15, 40);
	endfunction

	// Mix of extremes, near-zero values that tie often, and full-range words
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0:       random_word = 32'h8000_0000;
					1:       random_word = 32'h7fff_ffff;
					2:       random_word = 32'hffff_ffff;
					3:       random_word = 32'h0000_0001;
					default: random_word = 32'h0000_0000;
				endcase
			end
			1, 2, 3: random_word = $urandom_range(0, 16) - 8;
			default: random_word = $urandom;
		endcase
	endfunction

	// Offer one transaction after an optional gap, hold it until accepted
	task automatic offer(input logic [31:0] word, input logic last, input bit burst);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Well-formed set with random content, tlast on the final value
	task automatic send_set(input int len, input bit burst);
		int i;
		for (i = 0; i < len; i++) begin
			offer(random_word(), i == len - 1, burst);
		end
	endtask

	task automatic send_set_open(input int len, input bit burst);
		int i;
		for (i = 0; i < len; i++) begin
			offer(random_word(), 1'b0, burst);
		end
	endtask

	// Fill the store without tlast, then one more value that closes the set
	task automatic send_overflow_set(input logic extra_last, input bit burst);
		send_set_open(ims_pkg::MAX_ITEMS, burst);
		offer(random_word(), extra_last, burst);
	endtask

	// Hold the input idle until every owed word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
	endtask

	// Output side: ready runs and stalls, plus a long hold-off on request
	initial begin
		int r;
		m_tready     = 1'b0;
		holds_served = 0;
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end
			r = $urandom_range(0, 9);
			repeat ($urandom_range(1, r == 0 ? 80 : 12)) begin
				@(posedge clk);
				m_tready <= 1'b1;
			end
			r = $urandom_range(0, 99);
			repeat (r < 65 ? 0 : r < 88 ? $urandom_range(1, 3) :
				r < 98 ? $urandom_range(4, 12) : $urandom_range(20, 60)) begin
				@(posedge clk);
				m_tready <= 1'b0;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int set_idx;
		int k;
		bit burst;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		items_sent    = 0;
		hold_requests = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// single-value sets at both extremes
		offer(32'h8000_0000, 1'b1, 1'b0);
		offer(32'h7fff_ffff, 1'b1, 1'b0);
		// extremes, zero and a tie in one set
		offer(32'h7fff_ffff, 1'b0, 1'b1);
		offer(32'h8000_0000, 1'b0, 1'b1);
		offer(32'hffff_ffff, 1'b0, 1'b1);
		offer(32'h0000_0000, 1'b0, 1'b1);
		offer(32'hffff_ffff, 1'b1, 1'b1);
		// value past capacity without tlast: dropped, full set flushed
		send_overflow_set(1'b0, 1'b0);

		// random sets, mostly short, some long, a few past capacity
		set_idx = 0;
		while (items_sent < DIRECTED_CNT + RANDOM_CNT) begin
			burst = ($urandom_range(0, 3) == 0);
			if (set_idx == 8) begin
				// stall the output for a long stretch while input keeps coming
				hold_requests++;
				send_set(ims_pkg::MAX_ITEMS, 1'b1);
				send_set(ims_pkg::MAX_ITEMS, 1'b1);
				send_set($urandom_range(1, 6), 1'b1);
			end else if (set_idx == 4) begin
				wait_drained();
				send_set($urandom_range(1, ims_pkg::MAX_ITEMS), burst);
			end else begin
				k = $urandom_range(0, 19);
				if (k < 2)      send_overflow_set($urandom_range(0, 1), burst);
				else if (k < 3) send_set(ims_pkg::MAX_ITEMS, burst);
				else if (k < 6) send_set($urandom_range(7, ims_pkg::MAX_ITEMS), burst);
				else            send_set($urandom_range(1, 6), burst);
			end
			set_idx++;
		end

		wait_drained();
		repeat (4 * ims_pkg::MAX_ITEMS) @(posedge clk);

		$display("Sent %0d values in %0d sets; checked %0d sorted outputs, %0d mismatches.",
			items_sent, sets_closed, results_checked, mismatch_count);
		$display("Covered extremes, ties, full and past-capacity sets, and a long output stall.");
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
